// File: rtl/fmrp_pkg.sv
// Package for the face module response parser: framing constants,
// command codes and the byte-wide reflected CRC-16 update.
// Used by the parser core; depends on nothing.
package fmrp_pkg;

    localparam logic [7:0]  SYNC_A     = 8'h5A;
    localparam logic [7:0]  SYNC_B     = 8'h2C;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] MIN_LENGTH = 16'd10;

    // Frame byte positions that matter
    localparam int unsigned POS_LEN_HI = 4;
    localparam int unsigned POS_LEN_LO = 5;
    localparam int unsigned POS_CMD_HI = 6;
    localparam int unsigned POS_CMD_LO = 7;
    localparam int unsigned POS_BODY   = 8;
    localparam int unsigned POS_CAP0   = 16;
    localparam int unsigned POS_CAP3   = 19;
    localparam int unsigned CAP_DEPTH  = 4;

    // Response command codes
    localparam logic [15:0] CMD_ENROL_ACK    = 16'h030A;
    localparam logic [15:0] CMD_ENROL_RESULT = 16'h030D;
    localparam logic [15:0] CMD_IDENT_ACK    = 16'h020A;
    localparam logic [15:0] CMD_IDENT_RESULT = 16'h020D;
    localparam logic [15:0] CMD_DELETE_ACK   = 16'h040A;
    localparam logic [15:0] CMD_RESET_ACK    = 16'h0D0A;

    typedef struct packed {
        logic [15:0] face_id;
        logic        response_seen;
        logic        frame_done;
        logic        crc_good;
        logic [15:0] frame_command;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    // CRC after the sync byte 0x5A has been fed
    localparam logic [15:0] CRC_AFTER_SYNC = crc_feed(CRC_INIT, SYNC_A);

endpackage

// File: rtl/fmrp_if.sv
// Valid/ready channel interfaces for the face module response parser.
// Depends on nothing.
interface fmrp_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface fmrp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] face_id;
    logic        response_seen;
    logic        frame_done;
    logic        crc_good;
    logic [15:0] frame_command;

    modport source (output valid, output face_id, output response_seen,
                    output frame_done, output crc_good, output frame_command,
                    input ready);
    modport sink   (input valid, input face_id, input response_seen,
                    input frame_done, input crc_good, input frame_command,
                    output ready);
endinterface

// File: rtl/face_module_response_parser_core.sv
// Face module response parser: frames received bytes, checks CRC-16/X25,
// decodes response commands. Depends on fmrp_pkg and fmrp_if.
// The result of each accepted byte is registered in the output register.
// One byte per cycle unless the output stalls; the byte-wide CRC update
// and the frame decode sit between the receiver state and the output register.
// The input is taken whenever the output register is empty or being drained.
// Reset (rst_n low, asynchronous): receiver idle, CRC FFFF, face id and flag zero.
module face_module_response_parser_core #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    fmrp_in_if.sink    rx,
    fmrp_out_if.source rsp
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME + 2);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME);
    localparam int unsigned CAP_W = $clog2(fmrp_pkg::CAP_DEPTH);

    logic [7:0]       prev_reg,  prev_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [15:0]      len_reg,   len_next;
    logic [15:0]      crc_reg,   crc_next;
    logic [15:0]      cmd_reg,   cmd_next;
    logic [7:0]       cap_reg  [fmrp_pkg::CAP_DEPTH];
    logic [7:0]       cap_next [fmrp_pkg::CAP_DEPTH];
    logic [7:0]       hold_reg,  hold_next;
    logic [15:0]      face_reg,  face_next;
    logic             flag_reg,  flag_next;

    logic             out_valid_reg;
    fmrp_pkg::result_t res_reg, res_next;

    logic             accept;
    logic             sync;
    logic [POS_W-1:0] pos_cur;
    logic [15:0]      len_cur;
    logic [15:0]      crc_cur;
    logic [16:0]      p_ext;
    logic [16:0]      len_ext;
    logic             done;
    logic             good;

    assign rx.ready = !out_valid_reg || rsp.ready;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        sync    = (prev_reg == fmrp_pkg::SYNC_A) && (rx.rx_byte == fmrp_pkg::SYNC_B);
        pos_cur = sync ? POS_W'(1) : pos_reg;
        len_cur = sync ? 16'd0 : len_reg;
        crc_cur = sync ? fmrp_pkg::CRC_AFTER_SYNC : crc_reg;
        p_ext   = {{(17 - POS_W){1'b0}}, pos_cur};
        len_ext = {1'b0, len_cur};

        prev_next = prev_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        cmd_next  = cmd_reg;
        for (int i = 0; i < fmrp_pkg::CAP_DEPTH; i++)
            cap_next[i] = cap_reg[i];
        hold_next = hold_reg;
        face_next = face_reg;
        flag_next = flag_reg;
        done      = 1'b0;
        good      = 1'b0;

        if (rx.func) begin
            face_next = 16'd0;
            flag_next = 1'b0;
        end
        else begin
            prev_next = rx.rx_byte;
            pos_next  = pos_cur;
            len_next  = len_cur;
            crc_next  = crc_cur;
            if (pos_cur != '0 && pos_cur <= POS_LAST) begin
                if (pos_cur >= POS_W'(fmrp_pkg::POS_CAP0) &&
                    pos_cur <= POS_W'(fmrp_pkg::POS_CAP3))
                    cap_next[pos_cur[CAP_W-1:0]] = rx.rx_byte;

                if (pos_cur == POS_W'(fmrp_pkg::POS_LEN_HI))
                    len_next = {rx.rx_byte, len_cur[7:0]};
                else if (pos_cur == POS_W'(fmrp_pkg::POS_LEN_LO))
                    len_next = {len_cur[15:8], rx.rx_byte};
                else if (pos_cur == POS_W'(fmrp_pkg::POS_CMD_HI))
                    cmd_next = {rx.rx_byte, cmd_reg[7:0]};
                else if (pos_cur == POS_W'(fmrp_pkg::POS_CMD_LO))
                    cmd_next = {cmd_reg[15:8], rx.rx_byte};

                if (pos_cur < POS_W'(fmrp_pkg::POS_BODY) || p_ext + 17'd2 < len_ext)
                    crc_next = fmrp_pkg::crc_feed(crc_cur, rx.rx_byte);
                if (pos_cur >= POS_W'(fmrp_pkg::POS_BODY) && p_ext + 17'd2 == len_ext)
                    hold_next = rx.rx_byte;
                pos_next = pos_cur + POS_W'(1);

                if (pos_cur == POS_W'(fmrp_pkg::POS_CMD_LO)) begin
                    if (len_next < fmrp_pkg::MIN_LENGTH)
                        pos_next = '0;
                end
                else if (pos_cur >= POS_W'(fmrp_pkg::POS_BODY) &&
                         p_ext + 17'd1 == len_ext) begin
                    done     = 1'b1;
                    good     = (~crc_cur == {hold_reg, rx.rx_byte});
                    pos_next = '0;
                    len_next = 16'd0;
                    if (good) begin
                        case (cmd_reg)
                            fmrp_pkg::CMD_ENROL_ACK,
                            fmrp_pkg::CMD_IDENT_ACK,
                            fmrp_pkg::CMD_DELETE_ACK,
                            fmrp_pkg::CMD_RESET_ACK:
                                flag_next = 1'b1;
                            fmrp_pkg::CMD_ENROL_RESULT:
                            begin
                                flag_next = 1'b1;
                                face_next = (cap_next[2] == 8'd0) ?
                                            {cap_next[0], cap_next[1]} : 16'd0;
                            end
                            fmrp_pkg::CMD_IDENT_RESULT:
                            begin
                                flag_next = 1'b1;
                                face_next = (cap_next[3] == 8'd0) ?
                                            {cap_next[1], cap_next[2]} : 16'd0;
                            end
                            default:
                                flag_next = flag_reg;
                        endcase
                    end
                end
            end
        end

        res_next.face_id       = face_next;
        res_next.response_seen = flag_next;
        res_next.frame_done    = done;
        res_next.crc_good      = good;
        res_next.frame_command = done ? cmd_reg : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_reg <= 8'd0;
            pos_reg  <= '0;
            len_reg  <= 16'd0;
            crc_reg  <= fmrp_pkg::CRC_INIT;
            cmd_reg  <= 16'd0;
            for (int i = 0; i < fmrp_pkg::CAP_DEPTH; i++)
                cap_reg[i] <= 8'd0;
            hold_reg <= 8'd0;
            face_reg <= 16'd0;
            flag_reg <= 1'b0;
        end
        else if (accept) begin
            prev_reg <= prev_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            cmd_reg  <= cmd_next;
            for (int i = 0; i < fmrp_pkg::CAP_DEPTH; i++)
                cap_reg[i] <= cap_next[i];
            hold_reg <= hold_next;
            face_reg <= face_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // payload register, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.face_id       = res_reg.face_id;
    assign rsp.response_seen = res_reg.response_seen;
    assign rsp.frame_done    = res_reg.frame_done;
    assign rsp.crc_good      = res_reg.crc_good;
    assign rsp.frame_command = res_reg.frame_command;

endmodule
